/* rtl/lrufr_pkg.sv */
// ----------------------------------------------------------------------------
// lrufr_pkg
// Shared sizes and types for the LRU frame replacement unit.
// ----------------------------------------------------------------------------
package lrufr_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 16;
	localparam int AGE_BITS   = 16;
	localparam int IDX_BITS   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_BITS   = $clog2(MAX_FRAMES + 1);
	localparam int CFG_BITS   = 4;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [AGE_BITS-1:0]  age_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic  vld;
		logic  hit;
		idx_t  hit_idx;
		age_t  best_age;
		idx_t  best_idx;
		logic  best_valid;
		page_t best_page;
	} tok_t;

	// update command broadcast to all cells
	typedef struct packed {
		logic  en;
		logic  wr;
		idx_t  slot;
	} upd_t;

endpackage

/* rtl/lru_frame_replacement_unit.sv */
// ----------------------------------------------------------------------------
// lru_frame_replacement_unit
// LRU page replacement over a row of frame cells with age counters.
// ----------------------------------------------------------------------------
// One page reference is taken when start is high and busy is low. A scan
// token then walks the row of frame cells, one cell per cycle, picking up
// the first matching valid frame and the oldest active frame; after the last
// cell the decision is applied to every cell at once. The result appears on
// the result ports for one cycle with done high; done and the results are
// registered from the last cell's token, and the next reference can be
// taken in that same cycle. The receiver cannot stall, so results must be
// captured when done is high. frames_in_use is written through cfg_valid and
// cfg_ready while the unit is idle; 0 acts as 1 and values above the frame
// count act as the frame count.
// ----------------------------------------------------------------------------
module lru_frame_replacement_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [lrufr_pkg::PAGE_BITS-1:0]   page_number,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lrufr_pkg::CFG_BITS-1:0]    frames_in_use,
	output logic                              done,
	output logic                              was_hit,
	output logic [lrufr_pkg::IDX_BITS-1:0]    slot,
	output logic                              evicted_valid,
	output logic [lrufr_pkg::PAGE_BITS-1:0]   evicted_page
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN
	} state_t;

	state_t           state_q;
	lrufr_pkg::page_t page_q;
	lrufr_pkg::cnt_t  n_q;
	lrufr_pkg::cnt_t  filled_q;
	lrufr_pkg::tok_t  tok [lrufr_pkg::MAX_FRAMES+1];
	lrufr_pkg::tok_t  last;
	lrufr_pkg::upd_t  upd;
	lrufr_pkg::cnt_t  n_cfg;
	logic             fill;
	logic             done_q;
	logic             hit_q;
	lrufr_pkg::idx_t  slot_q;
	logic             ev_valid_q;
	lrufr_pkg::page_t ev_page_q;

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE;

	always_comb begin
		if (frames_in_use == '0) begin
			n_cfg = lrufr_pkg::cnt_t'(1);
		end else if (frames_in_use > lrufr_pkg::CFG_BITS'(lrufr_pkg::MAX_FRAMES)) begin
			n_cfg = lrufr_pkg::cnt_t'(lrufr_pkg::MAX_FRAMES);
		end else begin
			n_cfg = lrufr_pkg::cnt_t'(frames_in_use);
		end
	end

	always_comb begin
		tok[0]     = '0;
		tok[0].vld = state_q == S_LOAD;
	end

	genvar gi;
	generate
		for (gi = 0; gi < lrufr_pkg::MAX_FRAMES; gi++) begin : g_cell
			lrufr_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cell_idx (lrufr_pkg::idx_t'(gi)),
				.n_active (n_q),
				.page_ref (page_q),
				.tok_in   (tok[gi]),
				.upd      (upd),
				.tok_out  (tok[gi+1])
			);
		end
	endgenerate

	assign last = tok[lrufr_pkg::MAX_FRAMES];
	assign fill = !last.hit && (filled_q < n_q);

	always_comb begin
		upd.en = last.vld;
		upd.wr = !last.hit;
		if (last.hit) begin
			upd.slot = last.hit_idx;
		end else if (fill) begin
			upd.slot = filled_q[lrufr_pkg::IDX_BITS-1:0];
		end else begin
			upd.slot = last.best_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			page_q <= page_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= lrufr_pkg::cnt_t'(lrufr_pkg::MAX_FRAMES);
			filled_q   <= '0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			slot_q     <= '0;
			ev_valid_q <= 1'b0;
			ev_page_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				n_q <= n_cfg;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (last.vld) begin
						state_q    <= S_IDLE;
						done_q     <= 1'b1;
						hit_q      <= last.hit;
						slot_q     <= upd.slot;
						ev_valid_q <= !last.hit && !fill && last.best_valid;
						ev_page_q  <= (!last.hit && !fill && last.best_valid) ?
							last.best_page : '0;
						if (fill) begin
							filled_q <= filled_q + lrufr_pkg::cnt_t'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign was_hit       = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer did not start a scan");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= lrufr_pkg::cnt_t'(lrufr_pkg::MAX_FRAMES))
		else $error("fill count beyond frame count");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_hit |-> !evicted_valid)
		else $error("eviction reported on a hit");

	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last.vld |-> state_q == S_SCAN)
		else $error("scan token outside a scan");
`endif

endmodule

/* rtl/lrufr_cell.sv */
// ----------------------------------------------------------------------------
// lrufr_cell
// One frame of the replacement table: holds page, valid bit and age, and
// folds its entry into the scan token passed on to the next cell.
// ----------------------------------------------------------------------------
module lrufr_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  lrufr_pkg::idx_t cell_idx,
	input  lrufr_pkg::cnt_t n_active,
	input  lrufr_pkg::page_t page_ref,
	input  lrufr_pkg::tok_t tok_in,
	input  lrufr_pkg::upd_t upd,
	output lrufr_pkg::tok_t tok_out
);

	localparam lrufr_pkg::age_t AGE_MAX = '1;

	lrufr_pkg::page_t page_q;
	logic             valid_q;
	lrufr_pkg::age_t  age_q;
	lrufr_pkg::tok_t  tok_q;
	lrufr_pkg::tok_t  tok_nxt;
	logic             active;
	logic             sel;

	assign active = lrufr_pkg::cnt_t'(cell_idx) < n_active;
	assign sel    = upd.slot == cell_idx;

	always_comb begin
		tok_nxt = tok_in;
		if (active && valid_q && (page_q == page_ref) && !tok_in.hit) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.hit_idx = cell_idx;
		end
		if (active && (age_q >= tok_in.best_age)) begin
			tok_nxt.best_age   = age_q;
			tok_nxt.best_idx   = cell_idx;
			tok_nxt.best_valid = valid_q;
			tok_nxt.best_page  = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (tok_in.vld) begin
			tok_q <= tok_nxt;
		end else begin
			tok_q.vld <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (upd.en) begin
			if (sel) begin
				age_q <= lrufr_pkg::age_t'(1);
				if (upd.wr) begin
					valid_q <= 1'b1;
				end
			end else if (age_q != AGE_MAX) begin
				age_q <= age_q + lrufr_pkg::age_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && sel && upd.wr) begin
			page_q <= page_ref;
		end
	end

	assign tok_out = tok_q;

endmodule
